### hw/rtl/chime_pkg.sv
// chime_pkg: widths, register codes, reset values and the quarter-wave sine table
// for the four-tone chime synthesizer; no dependencies
package chime_pkg;

  localparam int NUM_TONES        = 4;
  localparam int PHASE_BITS       = 24;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int MAX_SAMPLES      = 4096;
  localparam int TUNE_REGS        = 4;

  localparam int TUNE_BITS      = 23;
  localparam int DECAY_BITS     = 31;
  localparam int BLOCK_BITS     = 13;
  localparam int CFG_DATA_BITS  = 31;
  localparam int CFG_INDEX_BITS = 3;
  localparam int SAMPLE_BITS    = 16;
  localparam int MAGTAB_BITS    = 15;

  localparam int ENV_BITS   = 31;
  localparam int COUNT_BITS = $clog2(MAX_SAMPLES);
  localparam int LEN_BITS   = $clog2(MAX_SAMPLES + 1);
  localparam int ADDR_BITS  = $clog2(SINE_TABLE_DEPTH);
  localparam int QTR_BITS   = ADDR_BITS - 2;
  localparam int QTR_DEPTH  = SINE_TABLE_DEPTH / 4;
  localparam int SUM_BITS   = SAMPLE_BITS + $clog2(NUM_TONES);
  localparam int MAG_BITS   = SUM_BITS - 1;
  localparam int PROD_BITS  = MAG_BITS + ENV_BITS;
  // sum * env / (NUM_TONES * 2^31), NUM_TONES a power of two
  localparam int DIV_SHIFT  = $clog2(NUM_TONES) + 31;

  localparam logic [ENV_BITS-1:0]   ENV_ONE       = ENV_BITS'(64'd1 << 30);
  localparam logic [DECAY_BITS-1:0] DECAY_RESET   = DECAY_BITS'(67109);
  localparam logic [BLOCK_BITS-1:0] BLOCK_RESET   = BLOCK_BITS'(4096);
  localparam int                    SAMPLE_MAX    = 32767;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  localparam cfg_index_t REG_TUNE_FIRST    = 3'd0;
  localparam cfg_index_t REG_TUNE_SECOND   = 3'd1;
  localparam cfg_index_t REG_TUNE_THIRD    = 3'd2;
  localparam cfg_index_t REG_TUNE_FOURTH   = 3'd3;
  localparam cfg_index_t REG_DECAY_STEP    = 3'd4;
  localparam cfg_index_t REG_BLOCK_SAMPLES = 3'd5;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [MAGTAB_BITS-1:0]        mag_t;
  typedef logic [ADDR_BITS-1:0]          sine_addr_t;
  typedef mag_t                          qtab_t [QTR_DEPTH];

  // first pipeline stage: looked-up tone values with envelope and end-of-block flag
  typedef struct packed {
    logic [NUM_TONES-1:0][SAMPLE_BITS-1:0] tone;
    logic [ENV_BITS-1:0]                   env;
    logic                                  last;
  } s1_t;

  function automatic logic [TUNE_BITS-1:0] tune_reset(int j);
    logic [TUNE_BITS-1:0] v;
    case (j)
      0:       v = TUNE_BITS'(548667);
      1:       v = TUNE_BITS'(691274);
      2:       v = TUNE_BITS'(822073);
      3:       v = TUNE_BITS'(1097335);
      default: v = '0;
    endcase
    return v;
  endfunction

  // q30 product, rounded half up on the magnitude
  function automatic longint mul_q30(longint a, longint b);
    logic        neg;
    logic [63:0] ua;
    logic [63:0] ub;
    logic [63:0] r;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? 64'(-a) : 64'(a);
    ub  = (b < 0) ? 64'(-b) : 64'(b);
    r   = ((ua * ub) + (64'd1 << 29)) >> 30;
    return neg ? -signed'(r) : signed'(r);
  endfunction

  // odd degree-9 series of sin(pi/2 * x), x in q30
  function automatic longint quarter_sine_q30(longint x);
    longint x2;
    longint p;
    x2 = mul_q30(x, x);
    p  = 64'sd172273;
    p  = -64'sd5026997 + mul_q30(p, x2);
    p  = 64'sd85569306 + mul_q30(p, x2);
    p  = -64'sd693598670 + mul_q30(p, x2);
    p  = 64'sd1686629713 + mul_q30(p, x2);
    return mul_q30(p, x);
  endfunction

  function automatic mag_t qsine_mag(int k);
    longint      x;
    longint      s;
    logic [63:0] t;
    x = longint'(k) <<< (32 - ADDR_BITS);
    s = quarter_sine_q30(x);
    if (s < 0) s = 0;
    t = ((64'(s) * 64'd32767) + (64'd1 << 29)) >> 30;
    if (t > 64'd32767) t = 64'd32767;
    return MAGTAB_BITS'(t);
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t tab;
    for (int k = 0; k < QTR_DEPTH; k++) begin
      tab[k] = qsine_mag(k);
    end
    return tab;
  endfunction

  localparam qtab_t QSINE      = build_qtab();
  localparam mag_t  QSINE_PEAK = qsine_mag(QTR_DEPTH);

  // full-wave read through the quarter table
  function automatic sample_t sine_lookup(sine_addr_t idx);
    logic [1:0]          quad;
    logic [QTR_BITS-1:0] r;
    logic [QTR_BITS-1:0] rr;
    mag_t                mag;
    sample_t             v;
    quad = idx[ADDR_BITS-1 -: 2];
    r    = idx[QTR_BITS-1:0];
    rr   = QTR_BITS'(0) - r;
    if (quad[0]) begin
      mag = (r == '0) ? QSINE_PEAK : QSINE[rr];
    end else begin
      mag = QSINE[r];
    end
    v = {1'b0, mag};
    return quad[1] ? -v : v;
  endfunction

endpackage

### hw/rtl/chime_req_if.sv
// chime_req_if: input channel of the chime synthesizer, one beat per tick
// depends on nothing
interface chime_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

### hw/rtl/chime_smp_if.sv
// chime_smp_if: result channel of the chime synthesizer, one audio sample per beat
// depends on chime_pkg
interface chime_smp_if;
  import chime_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

### hw/rtl/chime_mix.sv
// chime_mix: tone sum, envelope scaling and saturation, two pipeline stages
// ending in the output register; depends on chime_pkg and chime_smp_if
module chime_mix (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_valid,
  output logic              s1_ready,
  input  chime_pkg::s1_t    s1,
  chime_smp_if.source       out_chan
);
  import chime_pkg::*;

  logic                  s2_v_r;
  logic [MAG_BITS-1:0]   s2_mag_r;
  logic                  s2_neg_r;
  logic [ENV_BITS-1:0]   s2_env_r;
  logic                  s2_last_r;
  logic                  out_v_r;
  sample_t               out_sample_r;
  logic                  out_last_r;

  logic                  out_adv;
  logic                  s2_adv;
  logic signed [SUM_BITS-1:0] sum;
  logic signed [SUM_BITS-1:0] sum_abs;
  logic [PROD_BITS-1:0]  prod;
  logic [PROD_BITS-1:0]  quo;
  mag_t                  mag_sat;
  sample_t               smp_pos;
  sample_t               sample_nxt;

  assign out_adv  = !out_v_r || out_chan.ready;
  assign s2_adv   = !s2_v_r || out_adv;
  assign s1_ready = s2_adv;

  always_comb begin
    sum = '0;
    for (int j = 0; j < NUM_TONES; j++) begin
      sum = sum + SUM_BITS'($signed(s1.tone[j]));
    end
    sum_abs = sum[SUM_BITS-1] ? -sum : sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_adv) begin
      s2_v_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid) begin
      s2_mag_r  <= sum_abs[MAG_BITS-1:0];
      s2_neg_r  <= sum[SUM_BITS-1];
      s2_env_r  <= s1.env;
      s2_last_r <= s1.last;
    end
  end

  // scale by envelope, divide by tone count and 2^31, then clamp
  always_comb begin
    prod       = PROD_BITS'(s2_mag_r) * PROD_BITS'(s2_env_r);
    quo        = prod >> DIV_SHIFT;
    mag_sat    = (quo > PROD_BITS'(SAMPLE_MAX)) ? MAGTAB_BITS'(SAMPLE_MAX)
                                                : quo[MAGTAB_BITS-1:0];
    smp_pos    = {1'b0, mag_sat};
    sample_nxt = s2_neg_r ? -smp_pos : smp_pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_adv) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s2_v_r) begin
      out_sample_r <= sample_nxt;
      out_last_r   <= s2_last_r;
    end
  end

  assign out_chan.valid  = out_v_r;
  assign out_chan.sample = out_sample_r;
  assign out_chan.last   = out_last_r;

endmodule

### hw/rtl/decaying_four_tone_chime_synth.sv
// decaying_four_tone_chime_synth: top level, configuration registers, voice state
// and sine lookup; depends on chime_pkg, chime_req_if, chime_smp_if, chime_mix
//
//   channel   | direction | beat contents          | handshake
//   in_chan   | in        | restart                | valid / ready
//   out_chan  | out       | sample, last           | valid / ready
//   cfg_*     | in        | cfg_index, cfg_data    | cfg_we, no wait
//
// one sample per clock sustained while out_chan takes beats; a beat taken from in_chan
// passes the lookup register, the sum register and the output register to out_chan
// reset is synchronous; no table or memory needs clearing
// each stage moves when the one after it is empty or moving, so in_chan.ready
// drops only when all three stages hold a beat and out_chan is not taking one
module decaying_four_tone_chime_synth (
  input  logic                               clk,
  input  logic                               rst_n,
  chime_req_if.sink                          in_chan,
  chime_smp_if.source                        out_chan,
  input  logic                               cfg_we,
  input  chime_pkg::cfg_index_t              cfg_index,
  input  logic [chime_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import chime_pkg::*;

  logic [TUNE_BITS-1:0]   tune_r [NUM_TONES];
  logic [DECAY_BITS-1:0]  decay_r;
  logic [BLOCK_BITS-1:0]  block_r;

  logic [PHASE_BITS-1:0]  phase_r [NUM_TONES];
  logic [PHASE_BITS-1:0]  phase_nxt [NUM_TONES];
  logic [PHASE_BITS-1:0]  phase_eff [NUM_TONES];
  logic [COUNT_BITS-1:0]  count_r;
  logic [COUNT_BITS-1:0]  count_nxt;
  logic [COUNT_BITS-1:0]  count_eff;
  logic [ENV_BITS-1:0]    env_r;
  logic [ENV_BITS-1:0]    env_nxt;
  logic [ENV_BITS-1:0]    env_eff;
  logic [LEN_BITS-1:0]    len;
  logic                   last;

  logic                   s1_v_r;
  s1_t                    s1_r;
  s1_t                    s1_nxt;
  logic                   mix_ready;
  logic                   in_ready;
  logic                   accept;

  assign in_ready      = !s1_v_r || mix_ready;
  assign in_chan.ready = in_ready;
  assign accept        = in_chan.valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r <= DECAY_RESET;
      block_r <= BLOCK_RESET;
      for (int j = 0; j < NUM_TONES; j++) begin
        tune_r[j] <= tune_reset(j);
      end
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        [REG_TUNE_FIRST:REG_TUNE_FOURTH]: begin
          for (int j = 0; j < NUM_TONES; j++) begin
            if (j < TUNE_REGS && cfg_index == cfg_index_t'(j)) begin
              tune_r[j] <= cfg_data[TUNE_BITS-1:0];
            end
          end
        end
        REG_DECAY_STEP:    decay_r <= cfg_data[DECAY_BITS-1:0];
        REG_BLOCK_SAMPLES: block_r <= cfg_data[BLOCK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // restart acts before the sample is made; block end rewinds after it
  always_comb begin
    count_eff = in_chan.restart ? '0 : count_r;
    env_eff   = in_chan.restart ? ENV_ONE : env_r;
    for (int j = 0; j < NUM_TONES; j++) begin
      phase_eff[j] = in_chan.restart ? '0 : phase_r[j];
    end

    if (block_r == '0) begin
      len = LEN_BITS'(1);
    end else if (32'(block_r) > 32'(MAX_SAMPLES)) begin
      len = LEN_BITS'(MAX_SAMPLES);
    end else begin
      len = LEN_BITS'(block_r);
    end
    last = (LEN_BITS'(count_eff) + LEN_BITS'(1)) >= len;

    if (last) begin
      count_nxt = '0;
      env_nxt   = ENV_ONE;
      for (int j = 0; j < NUM_TONES; j++) begin
        phase_nxt[j] = '0;
      end
    end else begin
      count_nxt = count_eff + COUNT_BITS'(1);
      env_nxt   = (env_eff > ENV_BITS'(decay_r)) ? env_eff - ENV_BITS'(decay_r) : '0;
      for (int j = 0; j < NUM_TONES; j++) begin
        phase_nxt[j] = phase_eff[j] + PHASE_BITS'(tune_r[j]);
      end
    end

    for (int j = 0; j < NUM_TONES; j++) begin
      s1_nxt.tone[j] = sine_lookup(phase_eff[j][PHASE_BITS-1 -: ADDR_BITS]);
    end
    s1_nxt.env  = env_eff;
    s1_nxt.last = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      env_r   <= ENV_ONE;
      for (int j = 0; j < NUM_TONES; j++) begin
        phase_r[j] <= '0;
      end
    end else if (accept) begin
      count_r <= count_nxt;
      env_r   <= env_nxt;
      for (int j = 0; j < NUM_TONES; j++) begin
        phase_r[j] <= phase_nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
  end

  chime_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_v_r),
    .s1_ready (mix_ready),
    .s1       (s1_r),
    .out_chan (out_chan)
  );

endmodule

### hw/rtl/chime_checker.sv
// chime_checker: port-level assertions for the chime synthesizer, bound to the top
// depends on chime_pkg
module chime_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_ready,
  input  logic               out_valid,
  input  logic               out_ready,
  input  chime_pkg::sample_t out_sample,
  input  logic               out_last
);
  import chime_pkg::*;

  logic first_r;

  // set until the first result beat after reset has gone out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
    end else if (out_valid && out_ready) begin
      first_r <= 1'b0;
    end
  end

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_sample) && $stable(out_last))
    else $error("stalled result beat changed");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output is free");

  a_first_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && first_r |-> out_sample == sample_t'(0))
    else $error("first sample after reset is not zero");

endmodule

bind decaying_four_tone_chime_synth chime_checker u_chime_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_sample (out_chan.sample),
  .out_last   (out_chan.last)
);

### bench/decaying_four_tone_chime_synth_test.sv
// decaying_four_tone_chime_synth_test: self-checking bench for the four-tone chime synth,
// with a bit-exact sample predictor and random valid/ready idling on both channels
// depends on chime_pkg, chime_req_if, chime_smp_if and decaying_four_tone_chime_synth
`timescale 1ns / 100ps

module decaying_four_tone_chime_synth_test;
  import chime_pkg::*;

  localparam int CYCLE_LIMIT = 250000;
  localparam int HOLD_CYCLES = 150;
  localparam int TUNE_MAX    = 8388607;
  localparam int MAX_PRINTS  = 20;

  localparam cfg_index_t REG_SPARE_LO = 3'd6;
  localparam cfg_index_t REG_SPARE_HI = 3'd7;
  localparam cfg_index_t TUNE_REG [NUM_TONES] =
    '{REG_TUNE_FIRST, REG_TUNE_SECOND, REG_TUNE_THIRD, REG_TUNE_FOURTH};
  localparam logic [TUNE_BITS-1:0] TUNE_DEFAULT [NUM_TONES] =
    '{23'd548667, 23'd691274, 23'd822073, 23'd1097335};

  typedef struct packed {
    sample_t sample;
    logic    last;
  } chime_beat_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_index_t cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  chime_req_if in_chan ();
  chime_smp_if out_chan ();

  decaying_four_tone_chime_synth dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor copy of configuration and voice state
  sample_t               sine_wave [SINE_TABLE_DEPTH];
  logic [TUNE_BITS-1:0]  tone_step [NUM_TONES];
  logic [DECAY_BITS-1:0] decay_amt;
  logic [BLOCK_BITS-1:0] blk_len;
  logic [COUNT_BITS-1:0] voice_count;
  logic [PHASE_BITS-1:0] voice_phase [NUM_TONES];
  logic [31:0]           voice_env;

  logic        restart_queue [$];
  chime_beat_t chime_due [$];
  chime_beat_t want;

  int in_idle_pct = 34;
  int out_idle_pct = 34;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int errors = 0;
  int beats_taken = 0;
  int restarts_taken = 0;
  int samples_seen = 0;
  int block_ends = 0;
  int settings_used = 0;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic longint q30_mul(longint a, longint b);
    logic        neg;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] r;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    r   = (ma * mb + (64'd1 << 29)) >> 30;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  // one table entry: odd series of sin on a folded quarter wave, then scaled to 32767
  function automatic sample_t wave_entry(int k);
    logic [1:0]  quad;
    longint      x;
    longint      x2;
    longint      p;
    longint      s;
    logic [63:0] t;
    quad = 2'(k / (SINE_TABLE_DEPTH / 4));
    x    = longint'(k % (SINE_TABLE_DEPTH / 4)) << (32 - ADDR_BITS);
    if (quad[0]) x = (64'sd1 << 30) - x;
    x2 = q30_mul(x, x);
    p  = 64'sd172273;
    p  = -64'sd5026997 + q30_mul(p, x2);
    p  = 64'sd85569306 + q30_mul(p, x2);
    p  = -64'sd693598670 + q30_mul(p, x2);
    p  = 64'sd1686629713 + q30_mul(p, x2);
    s  = q30_mul(p, x);
    if (s < 0) s = 0;
    t = (64'(s) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (t > 64'd32767) t = 64'd32767;
    return quad[1] ? -sample_t'(t) : sample_t'(t);
  endfunction

  function automatic void restart_voice();
    voice_count = '0;
    for (int j = 0; j < NUM_TONES; j++) voice_phase[j] = '0;
    voice_env = 32'd1 << 30;
  endfunction

  // sample for one tick; advances the voice state
  function automatic chime_beat_t next_chime_beat(logic restart);
    int          span;
    int          total;
    longint      scaled;
    logic        neg;
    chime_beat_t b;
    if (restart) restart_voice();
    span = int'(blk_len);
    if (span == 0) span = 1;
    if (span > MAX_SAMPLES) span = MAX_SAMPLES;
    total = 0;
    for (int j = 0; j < NUM_TONES; j++) begin
      total += int'(sine_wave[voice_phase[j][PHASE_BITS-1 -: ADDR_BITS]]);
    end
    neg    = total < 0;
    scaled = longint'(neg ? -total : total) * longint'(voice_env);
    scaled = scaled / (longint'(NUM_TONES) << 31);
    if (scaled > SAMPLE_MAX) scaled = SAMPLE_MAX;
    b.sample = neg ? -sample_t'(scaled) : sample_t'(scaled);
    b.last   = (int'(voice_count) + 1) >= span;
    if (b.last) begin
      restart_voice();
    end else begin
      voice_count = voice_count + 1'b1;
      for (int j = 0; j < NUM_TONES; j++) voice_phase[j] = voice_phase[j] + tone_step[j];
      voice_env = (voice_env > {1'b0, decay_amt}) ? voice_env - {1'b0, decay_amt} : '0;
    end
    return b;
  endfunction

  task automatic report_mismatch(string what);
    if (errors < MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // input driver: valid stays up until the beat is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid   <= 1'b0;
      in_chan.restart <= 1'b0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (restart_queue.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        in_chan.valid   <= 1'b1;
        in_chan.restart <= restart_queue.pop_front();
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // output sink: random ready, plus a long hold-off when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      hold_left      <= 0;
    end else if (hold_served != hold_requests) begin
      hold_served    <= hold_requests;
      hold_left      <= HOLD_CYCLES;
      out_chan.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left      <= hold_left - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= $urandom_range(99) >= out_idle_pct;
    end
  end

  // monitor: tracks register writes, predicts taken beats, checks result beats
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NUM_TONES; j++) tone_step[j] = TUNE_DEFAULT[j];
      decay_amt = DECAY_RESET;
      blk_len   = BLOCK_RESET;
      restart_voice();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TUNE_FIRST:    tone_step[0] = cfg_data[TUNE_BITS-1:0];
          REG_TUNE_SECOND:   tone_step[1] = cfg_data[TUNE_BITS-1:0];
          REG_TUNE_THIRD:    tone_step[2] = cfg_data[TUNE_BITS-1:0];
          REG_TUNE_FOURTH:   tone_step[3] = cfg_data[TUNE_BITS-1:0];
          REG_DECAY_STEP:    decay_amt    = cfg_data[DECAY_BITS-1:0];
          REG_BLOCK_SAMPLES: blk_len      = cfg_data[BLOCK_BITS-1:0];
          default: ;
        endcase
      end
      if (out_chan.valid && out_chan.ready) begin
        samples_seen++;
        if (chime_due.size() == 0) begin
          report_mismatch("result beat with no sample expected");
        end else begin
          want = chime_due.pop_front();
          if (want.last) block_ends++;
          if (out_chan.sample !== want.sample)
            report_mismatch($sformatf("sample %0d: got %0d, expected %0d", samples_seen,
                                      out_chan.sample, want.sample));
          if (out_chan.last !== want.last)
            report_mismatch($sformatf("sample %0d: last got %b, expected %b", samples_seen,
                                      out_chan.last, want.last));
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        beats_taken++;
        if (in_chan.restart) restarts_taken++;
        chime_due.push_back(next_chime_beat(in_chan.restart));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples outstanding", cycle_count,
               chime_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
  endtask

  task automatic close_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic queue_pattern(logic [31:0] pattern, int count);
    @(negedge clk);
    for (int i = 0; i < count; i++) restart_queue.push_back(pattern[i]);
  endtask

  task automatic queue_random(int count, int restart_pct);
    @(negedge clk);
    for (int i = 0; i < count; i++) restart_queue.push_back($urandom_range(99) < restart_pct);
  endtask

  // every beat accepted and every sample back, then an idle margin
  task automatic wait_drained();
    do @(negedge clk);
    while (restart_queue.size() != 0 || in_chan.valid || chime_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic pick_random_setup();
    logic [CFG_DATA_BITS-1:0] v;
    for (int j = 0; j < NUM_TONES; j++) begin
      case ($urandom_range(7))
        0:       v = '0;
        1:       v = CFG_DATA_BITS'(TUNE_MAX);
        2:       v = CFG_DATA_BITS'($urandom);
        default: v = CFG_DATA_BITS'($urandom_range(0, TUNE_MAX));
      endcase
      write_reg(TUNE_REG[j], v);
    end
    case ($urandom_range(9))
      0:       v = '0;
      1:       v = CFG_DATA_BITS'(32'd1 << 30);
      2:       v = '1;
      3:       v = CFG_DATA_BITS'($urandom);
      default: v = CFG_DATA_BITS'($urandom_range(0, 1 << 22));
    endcase
    write_reg(REG_DECAY_STEP, v);
    case ($urandom_range(9))
      0:       v = '0;
      1:       v = CFG_DATA_BITS'(1);
      2:       v = CFG_DATA_BITS'(MAX_SAMPLES);
      3:       v = CFG_DATA_BITS'($urandom_range(MAX_SAMPLES + 1, 8191));
      default: v = CFG_DATA_BITS'($urandom_range(2, 48));
    endcase
    write_reg(REG_BLOCK_SAMPLES, v);
    if ($urandom_range(3) == 0) write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                                          CFG_DATA_BITS'($urandom));
    close_writes();
  endtask

  initial begin
    rst_n           = 1'b0;
    in_chan.valid   = 1'b0;
    in_chan.restart = 1'b0;
    out_chan.ready  = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_TUNE_FIRST;
    cfg_data        = '0;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) sine_wave[k] = wave_entry(k);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, restart in the middle of a block
    queue_pattern(32'b1000, 6);
    wait_drained();

    // all tones at the top step, no decay, block length zero acts as one
    for (int j = 0; j < NUM_TONES; j++) write_reg(TUNE_REG[j], CFG_DATA_BITS'(TUNE_MAX));
    write_reg(REG_DECAY_STEP, '0);
    write_reg(REG_BLOCK_SAMPLES, '0);
    close_writes();
    queue_pattern(32'b010, 3);
    wait_drained();

    // silent tones, one-sample blocks
    for (int j = 0; j < NUM_TONES; j++) write_reg(TUNE_REG[j], '0);
    write_reg(REG_BLOCK_SAMPLES, CFG_DATA_BITS'(1));
    close_writes();
    queue_pattern(32'b00, 2);
    wait_drained();

    // envelope reaches its floor after one sample
    for (int j = 0; j < NUM_TONES; j++)
      write_reg(TUNE_REG[j], CFG_DATA_BITS'($urandom_range(0, TUNE_MAX)));
    write_reg(REG_DECAY_STEP, CFG_DATA_BITS'(32'd1 << 30));
    write_reg(REG_BLOCK_SAMPLES, CFG_DATA_BITS'(3));
    close_writes();
    queue_pattern(32'b0000, 4);
    wait_drained();

    // widest decay step
    write_reg(REG_DECAY_STEP, '1);
    write_reg(REG_BLOCK_SAMPLES, CFG_DATA_BITS'(2));
    close_writes();
    queue_pattern(32'b100, 3);
    wait_drained();

    // spare indexes are ignored, upper data bits are dropped
    write_reg(REG_SPARE_LO, CFG_DATA_BITS'($urandom));
    write_reg(REG_SPARE_HI, CFG_DATA_BITS'($urandom));
    write_reg(REG_TUNE_FIRST, CFG_DATA_BITS'(32'h7F80_0000 | $urandom_range(0, TUNE_MAX)));
    write_reg(REG_DECAY_STEP, CFG_DATA_BITS'(67109));
    write_reg(REG_BLOCK_SAMPLES, CFG_DATA_BITS'(32'h7FFF_E005));
    close_writes();
    queue_pattern(32'b0010, 4);
    wait_drained();

    // random settings; one phase without idling, two with a long output stall,
    // one heavy on restarts
    for (int ph = 0; ph < 12; ph++) begin
      pick_random_setup();
      @(negedge clk);
      in_idle_pct  = (ph == 4) ? 0 : 34;
      out_idle_pct = (ph == 4) ? 0 : 34;
      queue_random($urandom_range(80, 120), (ph == 7) ? 40 : 3);
      if (ph == 2 || ph == 9) hold_requests++;
      wait_drained();
    end

    // a long run with the length register at or above the maximum, no early block end
    for (int j = 0; j < NUM_TONES; j++)
      write_reg(TUNE_REG[j], CFG_DATA_BITS'($urandom_range(0, TUNE_MAX)));
    write_reg(REG_DECAY_STEP, CFG_DATA_BITS'($urandom_range(0, 1 << 18)));
    write_reg(REG_BLOCK_SAMPLES, CFG_DATA_BITS'($urandom_range(MAX_SAMPLES, 8191)));
    close_writes();
    queue_pattern(32'b1, 1);
    queue_random(120, 0);
    wait_drained();

    repeat (8) @(posedge clk);
    if (chime_due.size() != 0) report_mismatch("samples still expected at end of run");
    $display("covered %0d tick beats (%0d restarts), %0d samples and %0d block ends",
             beats_taken, restarts_taken, samples_seen, block_ends);
    $display("across %0d register settings, %0d mismatches", settings_used, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
